/* hdl/weighted_pending_load_forwarder_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the weighted pending load forwarder
// Implication checks for the assertions of the forwarder unit.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_PENDING_LOAD_FORWARDER_UNIT_ASSERT_SVH
`define WEIGHTED_PENDING_LOAD_FORWARDER_UNIT_ASSERT_SVH

// same-cycle implication
`define WPL_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("wpl assertion failed");

// next-cycle implication
`define WPL_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("wpl assertion failed");

`endif

/* hdl/wpl_pkg.sv */
// ---------------------------------------------------------------------------
// wpl_pkg
// Sizes, codes and record types of the weighted pending load forwarder.
// ---------------------------------------------------------------------------
package wpl_pkg;

   localparam int PREFIX_SLOTS = 64;
   localparam int FACE_SLOTS   = 8;
   localparam int MASK_W       = 8;
   localparam int MASK_FACES   = (FACE_SLOTS < MASK_W) ? FACE_SLOTS : MASK_W;
   localparam int ENTRIES      = PREFIX_SLOTS * FACE_SLOTS;
   localparam int ADDR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FIDX_W       = (MASK_FACES > 1) ? $clog2(MASK_FACES) : 1;
   localparam int CNT_W        = 32;
   localparam int AVG_W        = 48;
   localparam int WGT_W        = 17;
   localparam int TOT_W        = WGT_W + $clog2(MASK_FACES + 1);
   localparam int SF_W         = 16;

   localparam logic [SF_W-1:0]  SMOOTH_RESET = 16'd58982;
   localparam logic [WGT_W-1:0] ONE_Q16      = 17'h10000;
   localparam logic [15:0]      LABEL_BASE   = 16'd256;

   localparam logic [1:0] OP_INTEREST = 2'd0;
   localparam logic [1:0] OP_DATA     = 2'd1;
   localparam logic [1:0] OP_EXPIRE   = 2'd2;

   localparam logic [1:0] DEC_FORWARD = 2'd0;
   localparam logic [1:0] DEC_NACK    = 2'd1;
   localparam logic [1:0] DEC_UPDATE  = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [AVG_W-1:0] average;
      logic [WGT_W-1:0] weight;
   } wpl_entry_type;

   typedef struct packed {
      logic             done;
      logic [WGT_W-1:0] quotient;
   } wpl_div_result_type;

endpackage

/* hdl/wpl_channel_if.sv */
// ---------------------------------------------------------------------------
// wpl channel interfaces
// Valid/ready channels for requests and results of the forwarder.
// ---------------------------------------------------------------------------
interface wpl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [5:0]  prefix_slot;
   logic [2:0]  face_slot;
   logic [15:0] face_id;
   logic [7:0]  eligible_mask;
   logic        from_local;
   logic [15:0] random_fraction;
   logic        label_present;
   logic [63:0] label_in;

   modport source (output valid, operation, prefix_slot, face_slot, face_id, eligible_mask,
                   from_local, random_fraction, label_present, label_in, input ready);
   modport sink (input valid, operation, prefix_slot, face_slot, face_id, eligible_mask,
                 from_local, random_fraction, label_present, label_in, output ready);
endinterface

interface wpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  decision;
   logic [2:0]  chosen_face;
   logic        label_valid;
   logic [63:0] label_out;

   modport source (output valid, decision, chosen_face, label_valid, label_out, input ready);
   modport sink (input valid, decision, chosen_face, label_valid, label_out, output ready);
endinterface

/* hdl/wpl_store.sv */
// ---------------------------------------------------------------------------
// wpl_store
// Per prefix and face entry memory: count, average and weight, registered read.
// ---------------------------------------------------------------------------
module wpl_store (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [wpl_pkg::ADDR_W-1:0]    rd_addr,
   output wpl_pkg::wpl_entry_type        rd_data,
   input  logic                          wr_en,
   input  logic [wpl_pkg::ADDR_W-1:0]    wr_addr,
   input  wpl_pkg::wpl_entry_type        wr_data
);
   import wpl_pkg::*;

   wpl_entry_type mem [ENTRIES];
   wpl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/wpl_recip.sv */
// ---------------------------------------------------------------------------
// wpl_recip
// Restoring divider for 2^32 / average, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wpl_recip (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wpl_pkg::AVG_W-1:0]      divisor,
   output wpl_pkg::wpl_div_result_type    result
);
   import wpl_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [32:0]      rem_ff, rem_in;
   logic [4:0]       bit_ff, bit_in;
   logic [WGT_W-1:0] quo_ff, quo_in;
   logic [AVG_W-1:0] div_ff, div_in;
   logic [63:0]      trial;
   logic             fits;

   always_comb begin
      trial   = 64'(div_ff) << bit_ff;
      fits    = 64'(rem_ff) >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = 33'h1_0000_0000;
         bit_in  = 5'd16;
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial[32:0];
            quo_in = quo_ff | (WGT_W'(1) << bit_ff);
         end
         if (bit_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;
endmodule

/* hdl/weighted_pending_load_forwarder_unit.sv */
// Sequence: a weighted interest first scans the face weights and draws; the entry is
//   then read, updated and written back, dividing when the new average is >= 1.0.
// Requests are taken one at a time, so the read-modify-write of the entry memory,
//   the face weight scan and the bit-serial reciprocal bound the request rate.
// Reset: synchronous; a clearing pass writes every entry before the first request
//   is taken. Configuration writes are taken during the pass.
// ---------------------------------------------------------------------------
// weighted_pending_load_forwarder_unit
// Inverse-load weighted next-hop selection with pending counts held in memory.
// ---------------------------------------------------------------------------
`include "weighted_pending_load_forwarder_unit_assert.svh"

module weighted_pending_load_forwarder_unit (
   input  logic                 clock,
   input  logic                 reset,
   wpl_req_if.sink              req_chan,
   wpl_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_write_data
);
   import wpl_pkg::*;

   typedef enum logic [3:0] {
      CLEAR, IDLE, SCAN, PROD, DRAW, READ, LOAD, MUL, SUM, CHECK, DIV, WRITE, DONE
   } state_type;

   state_type            state_ff, state_in;

   // latched request
   logic [1:0]           op_ff, op_in;
   logic [15:0]          fid_ff, fid_in;
   logic [MASK_FACES-1:0] mask_ff, mask_in;
   logic [15:0]          rand_ff, rand_in;
   logic                 lpres_ff, lpres_in;
   logic [63:0]          label_ff, label_in;
   logic [1:0]           dec_ff, dec_in;

   // selection
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [ADDR_W-1:0]    tgt_ff, tgt_in;
   logic [FIDX_W-1:0]    pick_ff, pick_in;
   logic [FIDX_W-1:0]    last_ff, last_in;
   logic [FIDX_W:0]      idx_ff, idx_in;
   logic                 rdv_ff, rdv_in;
   logic [FIDX_W-1:0]    rdface_ff, rdface_in;
   logic [WGT_W-1:0]     wgt_ff [MASK_FACES];
   logic [WGT_W-1:0]     wgt_in [MASK_FACES];
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [TOT_W+15:0]    rt_ff, rt_in;
   logic [FIDX_W-1:0]    draw_ff, draw_in;
   logic [TOT_W-1:0]     cum_ff, cum_in;

   // entry update
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [39:0]          lo_ff, lo_in;
   logic [39:0]          hi_ff, hi_in;
   logic [48:0]          ct_ff, ct_in;
   logic [WGT_W-1:0]     weight_ff, weight_in;

   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [SF_W-1:0]      smooth_ff, smooth_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           out_dec_ff, out_dec_in;
   logic [2:0]           out_face_ff, out_face_in;
   logic                 out_lv_ff, out_lv_in;
   logic [63:0]          out_label_ff, out_label_in;

   // memory and divider hookup
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   wpl_entry_type        mem_rd_data;
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   wpl_entry_type        mem_wr_data;
   logic                 div_start;
   wpl_div_result_type   div_result;

   // scratch
   logic [MASK_FACES-1:0] req_mask;
   logic [FIDX_W:0]      n_elig;
   logic [FIDX_W-1:0]    first_e;
   logic [FIDX_W-1:0]    last_e;
   logic                 found;
   logic                 pfx_ok;
   logic                 face_ok;
   logic                 out_free;
   logic [TOT_W-1:0]     cum_next;
   logic [WGT_W-1:0]     inv_a;
   logic [63:0]          prod_sum;
   logic [63:0]          label_calc;
   logic [63:0]          label_add;

   wpl_store u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   wpl_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (avg_ff),
      .result  (div_result)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == IDLE);

   always_comb begin
      // eligibility summary of the incoming mask
      req_mask = req_chan.eligible_mask[MASK_FACES-1:0];
      n_elig   = '0;
      first_e  = '0;
      last_e   = '0;
      found    = 1'b0;
      for (int i = 0; i < MASK_FACES; i++) begin
         if (req_mask[i]) begin
            n_elig = n_elig + 1'b1;
            last_e = FIDX_W'(i);
            if (!found) begin
               first_e = FIDX_W'(i);
               found   = 1'b1;
            end
         end
      end
      pfx_ok  = 32'(req_chan.prefix_slot) < PREFIX_SLOTS;
      face_ok = 32'(req_chan.face_slot) < FACE_SLOTS;

      // weighted draw step
      cum_next = cum_ff + (mask_ff[draw_ff] ? TOT_W'(wgt_ff[draw_ff]) : TOT_W'(0));

      // average terms
      inv_a    = ONE_Q16 - WGT_W'(smooth_ff);
      prod_sum = {hi_ff, 24'b0} + {24'b0, lo_ff};

      // route label extension: label * 10 + (face id - 256), or face id - 256 with no label
      label_add  = 64'(fid_ff - LABEL_BASE);
      label_calc = lpres_ff ? ((label_ff << 3) + (label_ff << 1) + label_add) : label_add;

      state_in  = state_ff;
      op_in     = op_ff;
      fid_in    = fid_ff;
      mask_in   = mask_ff;
      rand_in   = rand_ff;
      lpres_in  = lpres_ff;
      label_in  = label_ff;
      dec_in    = dec_ff;
      base_in   = base_ff;
      tgt_in    = tgt_ff;
      pick_in   = pick_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      rdv_in    = 1'b0;
      rdface_in = rdface_ff;
      wgt_in    = wgt_ff;
      total_in  = total_ff;
      rt_in     = rt_ff;
      draw_in   = draw_ff;
      cum_in    = cum_ff;
      cnt_in    = cnt_ff;
      avg_in    = avg_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ct_in     = ct_ff;
      weight_in = weight_ff;
      clr_in    = clr_ff;
      smooth_in = csr_write_enable ? csr_write_data : smooth_ff;

      rsp_valid_in = (rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff;
      out_dec_in   = out_dec_ff;
      out_face_in  = out_face_ff;
      out_lv_in    = out_lv_ff;
      out_label_in = out_label_ff;

      mem_rd_en           = 1'b0;
      mem_rd_addr         = tgt_ff;
      mem_wr_en           = 1'b0;
      mem_wr_addr         = tgt_ff;
      mem_wr_data.count   = cnt_ff;
      mem_wr_data.average = avg_ff;
      mem_wr_data.weight  = weight_ff;
      div_start           = 1'b0;

      case (state_ff)
         CLEAR: begin
            // sweep every entry to its reset value
            mem_wr_en           = 1'b1;
            mem_wr_addr         = clr_ff;
            mem_wr_data.count   = '0;
            mem_wr_data.average = '0;
            mem_wr_data.weight  = ONE_Q16;
            clr_in              = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(ENTRIES - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.operation;
               fid_in   = req_chan.face_id;
               mask_in  = req_mask;
               rand_in  = req_chan.random_fraction;
               lpres_in = req_chan.label_present;
               label_in = req_chan.label_in;
               base_in  = ADDR_W'(32'(req_chan.prefix_slot) * FACE_SLOTS);
               last_in  = last_e;
               case (req_chan.operation)
                  OP_INTEREST: begin
                     dec_in  = DEC_FORWARD;
                     pick_in = first_e;
                     tgt_in  = ADDR_W'(32'(req_chan.prefix_slot) * FACE_SLOTS + 32'(first_e));
                     if (!pfx_ok || n_elig == '0) begin
                        dec_in   = DEC_NACK;
                        state_in = DONE;
                     end else if (req_chan.from_local || n_elig == (FIDX_W + 1)'(1)) begin
                        state_in = READ;
                     end else begin
                        idx_in   = '0;
                        total_in = '0;
                        state_in = SCAN;
                     end
                  end
                  OP_DATA, OP_EXPIRE: begin
                     dec_in = DEC_UPDATE;
                     tgt_in = ADDR_W'(32'(req_chan.prefix_slot) * FACE_SLOTS
                                      + 32'(req_chan.face_slot));
                     state_in = (pfx_ok && face_ok) ? READ : DONE;
                  end
                  default: begin
                     dec_in   = DEC_UPDATE;
                     state_in = DONE;
                  end
               endcase
            end
         end
         SCAN: begin
            // stream face weights out of memory and total the eligible ones
            if (idx_ff != (FIDX_W + 1)'(MASK_FACES)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = base_ff + ADDR_W'(idx_ff);
               idx_in      = idx_ff + 1'b1;
               rdv_in      = 1'b1;
               rdface_in   = idx_ff[FIDX_W-1:0];
            end
            if (rdv_ff) begin
               wgt_in[rdface_ff] = mem_rd_data.weight;
               if (mask_ff[rdface_ff]) begin
                  total_in = total_ff + TOT_W'(mem_rd_data.weight);
               end
            end
            if (idx_ff == (FIDX_W + 1)'(MASK_FACES) && !rdv_ff) begin
               state_in = PROD;
            end
         end
         PROD: begin
            rt_in    = (TOT_W + 16)'(rand_ff) * (TOT_W + 16)'(total_ff);
            draw_in  = '0;
            cum_in   = '0;
            state_in = DRAW;
         end
         DRAW: begin
            // walk the running weight sum; a miss falls to the last eligible face
            cum_in = cum_next;
            if (mask_ff[draw_ff] && rt_ff < {cum_next, 16'b0}) begin
               pick_in  = draw_ff;
               tgt_in   = base_ff + ADDR_W'(draw_ff);
               state_in = READ;
            end else if (draw_ff == FIDX_W'(MASK_FACES - 1)) begin
               pick_in  = last_ff;
               tgt_in   = base_ff + ADDR_W'(last_ff);
               state_in = READ;
            end else begin
               draw_in = draw_ff + 1'b1;
            end
         end
         READ: begin
            mem_rd_en = 1'b1;
            state_in  = LOAD;
         end
         LOAD: begin
            avg_in = mem_rd_data.average;
            if (op_ff == OP_INTEREST) begin
               cnt_in = (mem_rd_data.count == '1) ? mem_rd_data.count
                                                  : mem_rd_data.count + 1'b1;
            end else begin
               cnt_in = (mem_rd_data.count == '0) ? mem_rd_data.count
                                                  : mem_rd_data.count - 1'b1;
            end
            state_in = MUL;
         end
         MUL: begin
            lo_in    = {24'b0, smooth_ff} * {16'b0, avg_ff[23:0]};
            hi_in    = {24'b0, smooth_ff} * {16'b0, avg_ff[47:24]};
            ct_in    = 49'(inv_a) * 49'(cnt_ff);
            state_in = SUM;
         end
         SUM: begin
            avg_in   = prod_sum[63:16] + ct_ff[AVG_W-1:0];
            state_in = CHECK;
         end
         CHECK: begin
            if (avg_ff < AVG_W'(ONE_Q16)) begin
               weight_in = ONE_Q16;
               state_in  = WRITE;
            end else begin
               div_start = 1'b1;
               state_in  = DIV;
            end
         end
         DIV: begin
            if (div_result.done) begin
               weight_in = div_result.quotient;
               state_in  = WRITE;
            end
         end
         WRITE: begin
            mem_wr_en = 1'b1;
            state_in  = DONE;
         end
         DONE: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_dec_in   = dec_ff;
               out_face_in  = (dec_ff == DEC_FORWARD) ? 3'(pick_ff) : 3'd0;
               out_lv_in    = (op_ff == OP_DATA) && (fid_ff > LABEL_BASE);
               out_label_in = ((op_ff == OP_DATA) && (fid_ff > LABEL_BASE)) ? label_calc
                                                                            : 64'd0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         smooth_ff    <= SMOOTH_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         smooth_ff    <= smooth_in;
      end
      op_ff        <= op_in;
      fid_ff       <= fid_in;
      mask_ff      <= mask_in;
      rand_ff      <= rand_in;
      lpres_ff     <= lpres_in;
      label_ff     <= label_in;
      dec_ff       <= dec_in;
      base_ff      <= base_in;
      tgt_ff       <= tgt_in;
      pick_ff      <= pick_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      rdface_ff    <= rdface_in;
      wgt_ff       <= wgt_in;
      total_ff     <= total_in;
      rt_ff        <= rt_in;
      draw_ff      <= draw_in;
      cum_ff       <= cum_in;
      cnt_ff       <= cnt_in;
      avg_ff       <= avg_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ct_ff        <= ct_in;
      weight_ff    <= weight_in;
      out_dec_ff   <= out_dec_in;
      out_face_ff  <= out_face_in;
      out_lv_ff    <= out_lv_in;
      out_label_ff <= out_label_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.decision    = out_dec_ff;
   assign rsp_chan.chosen_face = out_face_ff;
   assign rsp_chan.label_valid = out_lv_ff;
   assign rsp_chan.label_out   = out_label_ff;

   // memory is written only by the clearing sweep or the write-back step
   `WPL_ASSERT_NOW(a_write_source, clock, reset, mem_wr_en, state_ff == CLEAR || state_ff == WRITE)
   // divider finishes only while the sequencer waits for it
   `WPL_ASSERT_NOW(a_div_owner, clock, reset, div_result.done, state_ff == DIV)
   // a finished request always lands in the result register
   `WPL_ASSERT_NEXT(a_result_load, clock, reset, state_ff == DONE && out_free, rsp_valid_ff)
endmodule

/* bench/weighted_pending_load_forwarder_unit_tb.sv */
// ---------------------------------------------------------------------------
// weighted_pending_load_forwarder_unit_tb
// Drives forwarding requests through the request channel, predicts each
// result with an in-bench model of the pending count, moving average and
// inverse-load weight tables, and compares results in order. Both channels
// idle and stall at random; the smoothing factor changes between phases.
// ---------------------------------------------------------------------------
module weighted_pending_load_forwarder_unit_tb;
   import wpl_pkg::*;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         DRAIN_CYCLES = 80;

   typedef struct {
      logic [1:0]  operation;
      logic [5:0]  prefix_slot;
      logic [2:0]  face_slot;
      logic [15:0] face_id;
      logic [7:0]  eligible_mask;
      logic        from_local;
      logic [15:0] random_fraction;
      logic        label_present;
      logic [63:0] label_in;
   } fwd_request_type;

   typedef struct {
      logic [1:0]  decision;
      logic [2:0]  chosen_face;
      logic        label_valid;
      logic [63:0] label_out;
   } fwd_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [15:0] csr_write_data;

   wpl_req_if req_bus ();
   wpl_rsp_if rsp_bus ();

   weighted_pending_load_forwarder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shadow tables of the block, index prefix*FACE_SLOTS+face
   bit [31:0] shadow_count [ENTRIES];
   bit [47:0] shadow_avg   [ENTRIES];
   bit [16:0] shadow_wgt   [ENTRIES];
   bit [15:0] shadow_smooth;

   fwd_request_type pending_reqs[$];
   fwd_result_type  expected_results[$];
   int  mismatch_count;
   int  send_gap;
   int  recv_gap;
   bit  gaps_on;
   logic recv_hold;
   bit  hold_go;

   // clock and the one reset pulse
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = '0;
      req_bus.prefix_slot = '0;
      req_bus.face_slot = '0;
      req_bus.face_id = '0;
      req_bus.eligible_mask = '0;
      req_bus.from_local = 1'b0;
      req_bus.random_fraction = '0;
      req_bus.label_present = 1'b0;
      req_bus.label_in = '0;
      rsp_bus.ready = 1'b0;
      recv_hold = 1'b0;
      fork
         forever #4 clock = ~clock;
         begin
            repeat (7) @(posedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   // refresh the moving average and the weight of one entry
   function automatic void refresh_entry(int idx);
      bit [63:0] a;
      bit [63:0] nxt;
      a = {48'd0, shadow_smooth};
      nxt = ((a * {16'd0, shadow_avg[idx]}) >> 16)
            + (64'd65536 - a) * {32'd0, shadow_count[idx]};
      shadow_avg[idx] = nxt[47:0];
      if (nxt[47:0] < 48'd65536)
         shadow_wgt[idx] = ONE_Q16;
      else
         shadow_wgt[idx] = 17'((64'd1 << 32) / {16'd0, nxt[47:0]});
   endfunction

   // predict the result of one accepted request and advance the tables
   function automatic fwd_result_type forward_outcome(fwd_request_type rq);
      fwd_result_type res;
      int pick, last, eligible, base, i, idx;
      bit [63:0] total, cum;
      res = '{DEC_UPDATE, 3'd0, 1'b0, 64'd0};
      pick = -1;
      last = -1;
      eligible = 0;
      total = 0;
      cum = 0;
      base = int'(rq.prefix_slot) * FACE_SLOTS;
      if (rq.operation == OP_INTEREST) begin
         res.decision = DEC_NACK;
         for (i = 0; i < MASK_FACES; i++) begin
            if (rq.eligible_mask[i]) begin
               if (eligible == 0 && rq.from_local) pick = i;
               eligible++;
               last = i;
               total += shadow_wgt[base + i];
            end
         end
         if (!rq.from_local && eligible == 1) begin
            pick = last;
         end else if (!rq.from_local && eligible > 1) begin
            // walk the running weight sum until the draw falls below it
            for (i = 0; i < MASK_FACES; i++) begin
               if (rq.eligible_mask[i] && pick < 0) begin
                  cum += shadow_wgt[base + i];
                  if ({48'd0, rq.random_fraction} * total < (cum << 16)) pick = i;
               end
            end
            if (pick < 0) pick = last;
         end
         if (pick >= 0) begin
            idx = base + pick;
            if (shadow_count[idx] != 32'hFFFF_FFFF) shadow_count[idx]++;
            refresh_entry(idx);
            res.decision = DEC_FORWARD;
            res.chosen_face = 3'(pick);
         end
      end else if (rq.operation == OP_DATA || rq.operation == OP_EXPIRE) begin
         idx = base + int'(rq.face_slot);
         if (shadow_count[idx] != 0) shadow_count[idx]--;
         refresh_entry(idx);
         if (rq.operation == OP_DATA && rq.face_id > LABEL_BASE) begin
            res.label_valid = 1'b1;
            res.label_out = rq.label_present
                            ? rq.label_in * 64'd10 + 64'(rq.face_id - LABEL_BASE)
                            : 64'(rq.face_id - LABEL_BASE);
         end
      end
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   // append one request to the send queue
   task automatic queue_request(fwd_request_type rq);
      pending_reqs.insert(pending_reqs.size(), rq);
   endtask

   // request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      fwd_request_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            rq.operation = req_bus.operation;
            rq.prefix_slot = req_bus.prefix_slot;
            rq.face_slot = req_bus.face_slot;
            rq.face_id = req_bus.face_id;
            rq.eligible_mask = req_bus.eligible_mask;
            rq.from_local = req_bus.from_local;
            rq.random_fraction = req_bus.random_fraction;
            rq.label_present = req_bus.label_present;
            rq.label_in = req_bus.label_in;
            expected_results.insert(expected_results.size(), forward_outcome(rq));
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            rq = pending_reqs.pop_front();
            req_bus.operation <= rq.operation;
            req_bus.prefix_slot <= rq.prefix_slot;
            req_bus.face_slot <= rq.face_slot;
            req_bus.face_id <= rq.face_id;
            req_bus.eligible_mask <= rq.eligible_mask;
            req_bus.from_local <= rq.from_local;
            req_bus.random_fraction <= rq.random_fraction;
            req_bus.label_present <= rq.label_present;
            req_bus.label_in <= rq.label_in;
            req_bus.valid <= 1'b1;
            send_gap = gaps_on ? draw_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor: compare against the oldest prediction, stall at random
   always @(posedge clock) begin
      fwd_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", {62'd0, rsp_bus.decision}, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.decision !== want.decision)
                  report_mismatch("decision", 64'(rsp_bus.decision), 64'(want.decision));
               if (rsp_bus.chosen_face !== want.chosen_face)
                  report_mismatch("chosen_face", 64'(rsp_bus.chosen_face),
                                  64'(want.chosen_face));
               if (rsp_bus.label_valid !== want.label_valid)
                  report_mismatch("label_valid", 64'(rsp_bus.label_valid),
                                  64'(want.label_valid));
               if (rsp_bus.label_out !== want.label_out)
                  report_mismatch("label_out", rsp_bus.label_out, want.label_out);
            end
         end
         if (recv_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 5) == 0) recv_gap = draw_gap();
         end
      end
   end

   // long receiver hold-off while the sender keeps offering requests
   initial begin
      wait (hold_go);
      @(posedge clock);
      recv_hold <= 1'b1;
      repeat (900) @(posedge clock);
      recv_hold <= 1'b0;
   end

   // hard limit on the run
   initial begin
      #16000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic fwd_request_type make_request(logic [1:0] op, logic [5:0] pfx,
                                                    logic [2:0] fc, logic [15:0] fid,
                                                    logic [7:0] msk, logic loc,
                                                    logic [15:0] rnd, logic lp,
                                                    logic [63:0] lbl);
      fwd_request_type rq;
      rq = '{op, pfx, fc, fid, msk, loc, rnd, lp, lbl};
      return rq;
   endfunction

   // random request, biased to a few prefixes so that counts build up
   function automatic fwd_request_type random_request();
      fwd_request_type rq;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) rq.operation = OP_INTEREST;
      else if (roll < 75) rq.operation = OP_DATA;
      else if (roll < 97) rq.operation = OP_EXPIRE;
      else rq.operation = OP_RESERVED;
      rq.prefix_slot = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3))
                                                  : 6'($urandom);
      rq.face_slot = 3'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 6) rq.face_id = 16'($urandom_range(257, 65535));
      else if (roll < 8) rq.face_id = 16'($urandom_range(0, 256));
      else rq.face_id = 16'($urandom);
      roll = $urandom_range(0, 9);
      if (roll == 0) rq.eligible_mask = 8'd0;
      else if (roll < 3) rq.eligible_mask = 8'd1 << $urandom_range(0, 7);
      else rq.eligible_mask = 8'($urandom);
      rq.from_local = ($urandom_range(0, 4) == 0);
      rq.random_fraction = 16'($urandom);
      rq.label_present = 1'($urandom);
      rq.label_in = {$urandom, $urandom};
      return rq;
   endfunction

   task automatic write_smoothing(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      shadow_smooth = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // hold until every request is sent and every result has come back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus: directed requests, then random phases at several smoothing settings
   initial begin
      logic [15:0] smooth_plan [5];
      int phase, k;
      mismatch_count = 0;
      gaps_on = 1'b1;
      hold_go = 1'b0;
      for (k = 0; k < ENTRIES; k++) begin
         shadow_count[k] = '0;
         shadow_avg[k] = '0;
         shadow_wgt[k] = ONE_Q16;
      end
      shadow_smooth = SMOOTH_RESET;
      smooth_plan = '{16'd0, 16'd65535, 16'hAAAA, 16'h5555, SMOOTH_RESET};
      wait (!reset);
      // written during the clearing pass, so it takes effect before any request
      write_smoothing(SMOOTH_RESET);

      // nack with an empty mask, for a remote and for a local interest
      queue_request(make_request(OP_INTEREST, 6'd0, 3'd0, 16'd0, 8'h00, 1'b0,
                                 16'd0, 1'b0, 64'd0));
      queue_request(make_request(OP_INTEREST, 6'd0, 3'd0, 16'd0, 8'h00, 1'b1,
                                 16'hFFFF, 1'b0, 64'd0));
      // local interest takes the first eligible face
      queue_request(make_request(OP_INTEREST, 6'd0, 3'd0, 16'd0, 8'h80, 1'b1,
                                 16'd0, 1'b0, 64'd0));
      queue_request(make_request(OP_INTEREST, 6'd63, 3'd0, 16'hFFFF, 8'hFF, 1'b1,
                                 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      // only one eligible face
      queue_request(make_request(OP_INTEREST, 6'd1, 3'd0, 16'd0, 8'h10, 1'b0,
                                 16'hFFFF, 1'b0, 64'd0));
      // weighted draw at both ends and the middle of the random fraction, then random draws
      queue_request(make_request(OP_INTEREST, 6'd2, 3'd0, 16'd0, 8'hFF, 1'b0,
                                 16'd0, 1'b0, 64'd0));
      queue_request(make_request(OP_INTEREST, 6'd2, 3'd0, 16'd0, 8'hFF, 1'b0,
                                 16'hFFFF, 1'b0, 64'd0));
      queue_request(make_request(OP_INTEREST, 6'd2, 3'd0, 16'd0, 8'h81, 1'b0,
                                 16'h8000, 1'b0, 64'd0));
      for (k = 0; k < 4; k++)
         queue_request(make_request(OP_INTEREST, 6'd2, 3'd0, 16'd0, 8'h03, 1'b0,
                                    16'($urandom), 1'b0, 64'd0));
      // expiry on an empty entry saturates at zero; another on an entry in use
      queue_request(make_request(OP_EXPIRE, 6'd5, 3'd7, 16'hFFFF, 8'hFF, 1'b1,
                                 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_request(make_request(OP_EXPIRE, 6'd2, 3'd0, 16'd0, 8'h00, 1'b0,
                                 16'd0, 1'b0, 64'd0));
      // data: no label at face id 256 or 0, labels just above and at the top
      queue_request(make_request(OP_DATA, 6'd2, 3'd1, 16'd256, 8'h00, 1'b0,
                                 16'd0, 1'b1, 64'd7));
      queue_request(make_request(OP_DATA, 6'd2, 3'd7, 16'd257, 8'h00, 1'b0,
                                 16'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_request(make_request(OP_DATA, 6'd63, 3'd0, 16'hFFFF, 8'hFF, 1'b1,
                                 16'hFFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_request(make_request(OP_DATA, 6'd0, 3'd7, 16'd0, 8'h00, 1'b0,
                                 16'd0, 1'b0, 64'd0));
      // reserved operation answers an update with no label
      queue_request(make_request(OP_RESERVED, 6'd63, 3'd7, 16'hFFFF, 8'hFF, 1'b1,
                                 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_request(make_request(OP_RESERVED, 6'd0, 3'd0, 16'd0, 8'h00, 1'b0,
                                 16'd0, 1'b0, 64'd0));
      drain();

      for (phase = 0; phase < 5; phase++) begin
         write_smoothing(smooth_plan[phase]);
         // one phase runs back to back; another holds the receiver off
         gaps_on = (phase != 2);
         for (k = 0; k < 380; k++) queue_request(random_request());
         if (phase == 1) hold_go = 1'b1;
         drain();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
